// ----- hdl/aim_pkg.sv -----
// Shared types and constants for the append interval merge unit.
package aim_pkg;

  localparam int DEPTH      = 256;
  localparam int COORD_BITS = 32;
  localparam int IDX_W      = $clog2(DEPTH);
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int RIDX_W     = 8;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic [IDX_W-1:0]             idx_t;
  typedef logic [CNT_W-1:0]             cnt_t;

  typedef enum logic [1:0] {
    CMD_APPEND = 2'd0,
    CMD_READ   = 2'd1,
    CMD_CLEAR  = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_OVERFLOW  = 2'd1,
    STAT_BAD_INDEX = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_APPEND,
    ST_READ
  } state_t;

  // one write to both halves of an entry
  typedef struct packed {
    logic   en;
    idx_t   addr;
    coord_t seg_start;
    coord_t seg_end;
  } wr_req_t;

  // registered read result
  typedef struct packed {
    coord_t seg_start;
    coord_t seg_end;
  } rd_data_t;

endpackage

// ----- hdl/aim_store.sv -----
// Interval storage: start and end memories, one write and one registered read port.
module aim_store (
  input  logic              clk,
  input  aim_pkg::wr_req_t  wr,
  input  aim_pkg::idx_t     rd_addr,
  output aim_pkg::rd_data_t rd
);
  import aim_pkg::*;

  coord_t start_mem [DEPTH];
  coord_t end_mem   [DEPTH];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      start_mem[wr.addr] <= wr.seg_start;
      end_mem[wr.addr]   <= wr.seg_end;
    end
  end

  always_ff @(posedge clk) begin
    rd.seg_start <= start_mem[rd_addr];
    rd.seg_end   <= end_mem[rd_addr];
  end

endmodule

// ----- hdl/append_interval_merge_unit.sv -----
// Top level of the append interval merge unit: a stack of merged intervals.
//
// Keeps a sorted list of non-overlapping closed intervals on a stack held in
// two single-port-read memories (start and end, 256 entries each). An item
// is taken when start is high and busy is low; every item gives exactly one
// result, shown for one cycle with out_valid high, and the receiver cannot
// stall it. Flow: clear, an out-of-range read, an append to an empty list
// and the unused command finish in ST_IDLE; a read passes through ST_READ;
// an append to a non-empty list fetches the top entry, then compares in
// ST_APPEND once per popped entry and once more, unless the pops empty the
// list; every top entry is fetched through the registered memory read before
// it is compared. Each entry is popped at most once.
// The result appears the cycle after the item finishes, and the next item
// can be taken in that same cycle. Memory contents are not cleared; the
// entry count alone says what is valid.
module append_interval_merge_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  in_command,
  input  logic signed [31:0]          in_seg_start,
  input  logic signed [31:0]          in_seg_end,
  input  logic [aim_pkg::RIDX_W-1:0]  in_read_index,
  output logic                        out_valid,
  output logic [aim_pkg::CNT_W-1:0]   out_entry_count,
  output logic signed [31:0]          out_entry_start,
  output logic signed [31:0]          out_entry_end,
  output logic [1:0]                  out_status
);
  import aim_pkg::*;

  state_t   state_r, state_nxt;
  cnt_t     cnt_r, cnt_nxt;
  coord_t   a_r, a_nxt;     // start of the pending interval
  coord_t   b_r, b_nxt;     // end of the pending interval, widened by pops

  logic     out_valid_r, out_valid_nxt;
  cnt_t     out_cnt_r, out_cnt_nxt;
  coord_t   out_start_r, out_start_nxt;
  coord_t   out_end_r, out_end_nxt;
  status_t  out_status_r, out_status_nxt;

  wr_req_t  wr;
  idx_t     rd_addr;
  rd_data_t rd;

  logic     accept;
  cmd_t     cmd;
  cnt_t     ridx_ext;
  logic     read_ok;
  logic     pop;
  coord_t   b_wide;
  cnt_t     cnt_dec;
  cnt_t     cnt_dec2;

  aim_store u_store (
    .clk     (clk),
    .wr      (wr),
    .rd_addr (rd_addr),
    .rd      (rd)
  );

  assign busy     = (state_r != ST_IDLE);
  assign accept   = start && !busy;
  assign cmd      = cmd_t'(in_command);
  assign ridx_ext = CNT_W'(in_read_index);
  assign read_ok  = (ridx_ext < cnt_r);
  assign cnt_dec  = cnt_r - CNT_W'(1);
  assign cnt_dec2 = cnt_r - CNT_W'(2);

  // top of stack starts at or after the new start: it gets swallowed
  assign pop    = (rd.seg_start >= a_r);
  assign b_wide = (rd.seg_end > b_r) ? rd.seg_end : b_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (cmd)
            CMD_APPEND: if (cnt_r != '0) state_nxt = ST_APPEND;
            CMD_READ:   if (read_ok) state_nxt = ST_READ;
            default:    state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_APPEND: begin
        // keep popping while more entries remain to compare
        if (!(pop && cnt_r != CNT_W'(1))) state_nxt = ST_IDLE;
      end
      ST_READ:  state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // datapath, memory control and result
  always_comb begin
    cnt_nxt        = cnt_r;
    a_nxt          = a_r;
    b_nxt          = b_r;
    wr             = '0;
    rd_addr        = cnt_dec[IDX_W-1:0];
    out_valid_nxt  = 1'b0;
    out_cnt_nxt    = out_cnt_r;
    out_start_nxt  = '0;
    out_end_nxt    = '0;
    out_status_nxt = STAT_OK;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (cmd)
            CMD_APPEND: begin
              a_nxt = in_seg_start;
              b_nxt = in_seg_end;
              if (cnt_r == '0) begin
                // empty list: push straight away
                wr.en         = 1'b1;
                wr.addr       = '0;
                wr.seg_start  = in_seg_start;
                wr.seg_end    = in_seg_end;
                cnt_nxt       = CNT_W'(1);
                out_valid_nxt = 1'b1;
                out_cnt_nxt   = CNT_W'(1);
              end
              // otherwise fetch the top entry
            end
            CMD_READ: begin
              rd_addr = ridx_ext[IDX_W-1:0];
              if (!read_ok) begin
                out_valid_nxt  = 1'b1;
                out_cnt_nxt    = cnt_r;
                out_status_nxt = STAT_BAD_INDEX;
              end
            end
            CMD_CLEAR: begin
              cnt_nxt       = '0;
              out_valid_nxt = 1'b1;
              out_cnt_nxt   = '0;
            end
            default: begin
              out_valid_nxt = 1'b1;
              out_cnt_nxt   = cnt_r;
            end
          endcase
        end
      end

      ST_APPEND: begin
        if (pop) begin
          b_nxt   = b_wide;
          cnt_nxt = cnt_dec;
          rd_addr = cnt_dec2[IDX_W-1:0];
          if (cnt_r == CNT_W'(1)) begin
            // list emptied: push at the bottom
            wr.en         = 1'b1;
            wr.addr       = '0;
            wr.seg_start  = a_r;
            wr.seg_end    = b_wide;
            cnt_nxt       = CNT_W'(1);
            out_valid_nxt = 1'b1;
            out_cnt_nxt   = CNT_W'(1);
          end
        end else begin
          out_valid_nxt = 1'b1;
          out_cnt_nxt   = cnt_r;
          if (rd.seg_end < a_r) begin
            // disjoint from top: push, unless full (only when nothing popped)
            if (cnt_r == CNT_W'(DEPTH)) begin
              out_status_nxt = STAT_OVERFLOW;
            end else begin
              wr.en        = 1'b1;
              wr.addr      = cnt_r[IDX_W-1:0];
              wr.seg_start = a_r;
              wr.seg_end   = b_r;
              cnt_nxt      = cnt_r + CNT_W'(1);
              out_cnt_nxt  = cnt_r + CNT_W'(1);
            end
          end else if (rd.seg_end < b_r) begin
            // overlaps top: stretch its end
            wr.en        = 1'b1;
            wr.addr      = cnt_dec[IDX_W-1:0];
            wr.seg_start = rd.seg_start;
            wr.seg_end   = b_r;
          end
        end
      end

      ST_READ: begin
        out_valid_nxt = 1'b1;
        out_cnt_nxt   = cnt_r;
        out_start_nxt = rd.seg_start;
        out_end_nxt   = rd.seg_end;
      end

      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r <= a_nxt;
    b_r <= b_nxt;
    if (out_valid_nxt) begin
      out_cnt_r    <= out_cnt_nxt;
      out_start_r  <= out_start_nxt;
      out_end_r    <= out_end_nxt;
      out_status_r <= out_status_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_entry_count = out_cnt_r;
  assign out_entry_start = out_start_r;
  assign out_entry_end   = out_end_r;
  assign out_status      = out_status_r;

endmodule
